// File: src/ctcg_pkg.sv
// ctcg_pkg: shared widths, register indexes and transaction types for the
// CTC greedy decoder. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ctcg_pkg;

   // Field widths
   localparam int SCORE_BITS    = 16;
   localparam int CLASS_BITS    = 13;
   localparam int NCLASS_BITS   = 14;
   localparam int STEP_BITS     = 8;
   localparam int SEQ_BITS      = 9;
   localparam int MAX_CLASSES   = 8192;
   localparam int MAX_STEPS     = 256;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 14;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLASS_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_STEPS  = 2'd1;
   localparam logic [NCLASS_BITS-1:0]    CLASS_COUNT_RESET = 14'd6625;
   localparam logic [SEQ_BITS-1:0]       LINE_STEPS_RESET  = 9'd40;

   // Queue sizes
   localparam int STEP_Q_DEPTH    = 4;
   localparam int STEP_Q_PTR_BITS = $clog2(STEP_Q_DEPTH);
   localparam int STEP_Q_CNT_BITS = $clog2(STEP_Q_DEPTH + 1);
   localparam int OUT_Q_DEPTH     = 4;
   localparam int OUT_Q_PTR_BITS  = $clog2(OUT_Q_DEPTH);
   localparam int OUT_Q_CNT_BITS  = $clog2(OUT_Q_DEPTH + 1);

   // One decoded result transaction
   typedef struct packed {
      logic [CLASS_BITS-1:0] char_index;
      logic                  char_valid;
      logic                  end_of_text;
   } rsp_type;

endpackage : ctcg_pkg

`default_nettype wire

// File: src/ctcg_front.sv
// ctcg_front: accepts scores and tracks the per-step arg-max (first on ties).
// Depends on ctcg_pkg. Emits one winning class per completed time step.
`timescale 1ns / 1ps
`default_nettype none

module ctcg_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire logic signed [ctcg_pkg::SCORE_BITS-1:0]  score,
   input  wire logic [ctcg_pkg::NCLASS_BITS-1:0] class_limit,
   output logic                                 step_push,
   output logic [ctcg_pkg::CLASS_BITS-1:0]      step_class
);
   import ctcg_pkg::*;

   logic signed [SCORE_BITS-1:0] running_max_ff, running_max_in;
   logic [CLASS_BITS-1:0]        best_class_ff, best_class_in;
   logic [CLASS_BITS-1:0]        class_count_ff, class_count_in;
   logic [NCLASS_BITS-1:0]       count_inc;
   logic                         take;
   logic                         step_end;

   // Compare against the running maximum; the first class of a step always wins
   always_comb begin
      take      = (class_count_ff == '0) || (score > running_max_ff);
      count_inc = {1'b0, class_count_ff} + NCLASS_BITS'(1);
      step_end  = (count_inc >= class_limit);

      running_max_in = running_max_ff;
      best_class_in  = best_class_ff;
      class_count_in = class_count_ff;
      if (accept) begin
         if (take) begin
            running_max_in = score;
            best_class_in  = class_count_ff;
         end
         class_count_in = step_end ? '0 : count_inc[CLASS_BITS-1:0];
      end
   end

   // Hand the step winner to the queue on the last score of a step
   assign step_push  = accept & step_end;
   assign step_class = take ? class_count_ff : best_class_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_max_ff <= '0;
         best_class_ff  <= '0;
         class_count_ff <= '0;
      end else begin
         running_max_ff <= running_max_in;
         best_class_ff  <= best_class_in;
         class_count_ff <= class_count_in;
      end
   end

endmodule : ctcg_front

`default_nettype wire

// File: src/ctcg_step_queue.sv
// ctcg_step_queue: short FIFO of step winners between front and back.
// Depends on ctcg_pkg for the depth and class width.
`timescale 1ns / 1ps
`default_nettype none

module ctcg_step_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [ctcg_pkg::CLASS_BITS-1:0] push_class,
   input  wire logic                       pop,
   output logic                            full,
   output logic                            head_valid,
   output logic [ctcg_pkg::CLASS_BITS-1:0] head_class
);
   import ctcg_pkg::*;

   logic [CLASS_BITS-1:0]      entry_ff [STEP_Q_DEPTH];
   logic [STEP_Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [STEP_Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [STEP_Q_CNT_BITS-1:0] count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign full       = (count_ff == STEP_Q_CNT_BITS'(STEP_Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_class = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      do_push   = push & ~full;
      do_pop    = pop & head_valid;
      wr_ptr_in = do_push ? wr_ptr_ff + STEP_Q_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + STEP_Q_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + STEP_Q_CNT_BITS'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - STEP_Q_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_class;
      end
   end

endmodule : ctcg_step_queue

`default_nettype wire

// File: src/ctcg_back.sv
// ctcg_back: collapses repeats, drops blanks, counts steps per line and
// queues the result transactions. Depends on ctcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctcg_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            step_valid,
   input  wire logic [ctcg_pkg::CLASS_BITS-1:0] step_class,
   input  wire logic [ctcg_pkg::SEQ_BITS-1:0]   step_limit,
   output logic                                 step_pop,
   input  wire logic                            rsp_pop,
   output logic                                 rsp_empty,
   output ctcg_pkg::rsp_type                    rsp_head
);
   import ctcg_pkg::*;

   logic [CLASS_BITS-1:0]     prev_class_ff, prev_class_in;
   logic                      prev_valid_ff, prev_valid_in;
   logic [STEP_BITS-1:0]      step_count_ff, step_count_in;
   logic [SEQ_BITS-1:0]       step_inc;
   logic                      survives;
   logic                      last_step;
   logic                      emit;
   rsp_type                   new_rsp;

   rsp_type                   out_ff [OUT_Q_DEPTH];
   logic [OUT_Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_Q_CNT_BITS-1:0] count_ff, count_in;
   logic                      out_full;
   logic                      do_push;
   logic                      do_pop;

   assign out_full  = (count_ff == OUT_Q_CNT_BITS'(OUT_Q_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign rsp_head  = out_ff[rd_ptr_ff];
   assign step_pop  = step_valid & ~out_full;

   // Collapse and blank removal for the step at the head of the queue
   always_comb begin
      survives  = (step_class != '0) && (!prev_valid_ff || (step_class != prev_class_ff));
      step_inc  = {1'b0, step_count_ff} + SEQ_BITS'(1);
      last_step = (step_inc >= step_limit);
      emit      = step_pop & (survives | last_step);

      new_rsp.char_index  = survives ? step_class : '0;
      new_rsp.char_valid  = survives;
      new_rsp.end_of_text = last_step;

      prev_class_in = prev_class_ff;
      prev_valid_in = prev_valid_ff;
      step_count_in = step_count_ff;
      if (step_pop) begin
         if (last_step) begin
            prev_class_in = '0;
            prev_valid_in = 1'b0;
            step_count_in = '0;
         end else begin
            prev_class_in = step_class;
            prev_valid_in = 1'b1;
            step_count_in = step_inc[STEP_BITS-1:0];
         end
      end
   end

   // Result queue pointers and occupancy
   always_comb begin
      do_push   = emit;
      do_pop    = rsp_pop & ~rsp_empty;
      wr_ptr_in = do_push ? wr_ptr_ff + OUT_Q_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + OUT_Q_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + OUT_Q_CNT_BITS'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - OUT_Q_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_class_ff <= '0;
         prev_valid_ff <= 1'b0;
         step_count_ff <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         prev_class_ff <= prev_class_in;
         prev_valid_ff <= prev_valid_in;
         step_count_ff <= step_count_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   // Store the result payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         out_ff[wr_ptr_ff] <= new_rsp;
      end
   end

   // Checks
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      count_ff <= OUT_Q_CNT_BITS'(OUT_Q_DEPTH))
      else $error("result queue overflow");

   a_empty_rsp_is_eot : assert property (@(posedge clock) disable iff (reset)
      (emit && !new_rsp.char_valid) |-> (new_rsp.end_of_text && new_rsp.char_index == '0))
      else $error("result without character must close the line");

   a_line_end_clears : assert property (@(posedge clock) disable iff (reset)
      (step_pop && last_step) |=> (!prev_valid_ff && step_count_ff == '0))
      else $error("line end did not clear step state");

   a_pop_needs_room : assert property (@(posedge clock) disable iff (reset)
      step_pop |-> (step_valid && !out_full))
      else $error("step consumed without result room");

endmodule : ctcg_back

`default_nettype wire

// File: src/ctc_greedy_decoder_unit.sv
// ctc_greedy_decoder_unit: top level of the CTC greedy (best-path) decoder.
// Depends on ctcg_pkg, ctcg_front, ctcg_step_queue and ctcg_back.
//
// Takes one signed Q8.8 class score per clock, time-step-major (class count
// scores per step, line length steps per line), finds each step's arg-max
// (first class wins ties), collapses repeats, drops the blank class 0 and
// returns surviving class indices; the final step of a line always returns a
// transaction with end_of_text set. Scores are taken at one per cycle while
// req_full is low; the front's single compare against the running maximum
// sets that figure. A step's winner is registered in the four-entry step
// queue, then ctcg_back writes its result into the four-entry result queue,
// so the input keeps flowing while results wait to be popped until both
// queues fill. Registers read as saturated: class count to 2..8192, line
// length to 1..256; write them only while the block is idle. csr_ready is
// always high.
`timescale 1ns / 1ps
`default_nettype none

module ctc_greedy_decoder_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Score input
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic signed [ctcg_pkg::SCORE_BITS-1:0] req_score,
   // Decoded results
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [ctcg_pkg::CLASS_BITS-1:0]          rsp_char_index,
   output logic                                     rsp_char_valid,
   output logic                                     rsp_end_of_text,
   // Configuration writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ctcg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ctcg_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import ctcg_pkg::*;

   localparam logic [NCLASS_BITS-1:0] NC_LOW  = NCLASS_BITS'(2);
   localparam logic [NCLASS_BITS-1:0] NC_HIGH = NCLASS_BITS'(MAX_CLASSES);
   localparam logic [SEQ_BITS-1:0]    SL_LOW  = SEQ_BITS'(1);
   localparam logic [SEQ_BITS-1:0]    SL_HIGH = SEQ_BITS'(MAX_STEPS);

   logic [NCLASS_BITS-1:0] class_cfg_ff, class_cfg_in;
   logic [SEQ_BITS-1:0]    steps_cfg_ff, steps_cfg_in;
   logic [NCLASS_BITS-1:0] class_limit;
   logic [SEQ_BITS-1:0]    step_limit;
   logic                   req_accept;
   logic                   step_push;
   logic [CLASS_BITS-1:0]  push_class;
   logic                   step_full;
   logic                   step_valid;
   logic [CLASS_BITS-1:0]  head_class;
   logic                   step_pop;
   rsp_type                rsp_head;

   // Register writes
   assign csr_ready = 1'b1;

   always_comb begin
      class_cfg_in = class_cfg_ff;
      steps_cfg_in = steps_cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CLASS_COUNT: class_cfg_in = csr_data[NCLASS_BITS-1:0];
            CSR_LINE_STEPS:  steps_cfg_in = csr_data[SEQ_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_cfg_ff <= CLASS_COUNT_RESET;
         steps_cfg_ff <= LINE_STEPS_RESET;
      end else begin
         class_cfg_ff <= class_cfg_in;
         steps_cfg_ff <= steps_cfg_in;
      end
   end

   // Saturate the register values to their working ranges
   always_comb begin
      if (class_cfg_ff < NC_LOW) begin
         class_limit = NC_LOW;
      end else if (class_cfg_ff > NC_HIGH) begin
         class_limit = NC_HIGH;
      end else begin
         class_limit = class_cfg_ff;
      end
      if (steps_cfg_ff < SL_LOW) begin
         step_limit = SL_LOW;
      end else if (steps_cfg_ff > SL_HIGH) begin
         step_limit = SL_HIGH;
      end else begin
         step_limit = steps_cfg_ff;
      end
   end

   assign req_full   = step_full;
   assign req_accept = req_push & ~step_full;

   ctcg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .score       (req_score),
      .class_limit (class_limit),
      .step_push   (step_push),
      .step_class  (push_class)
   );

   ctcg_step_queue u_step_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (step_push),
      .push_class (push_class),
      .pop        (step_pop),
      .full       (step_full),
      .head_valid (step_valid),
      .head_class (head_class)
   );

   ctcg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid),
      .step_class (head_class),
      .step_limit (step_limit),
      .step_pop   (step_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_head   (rsp_head)
   );

   assign rsp_char_index  = rsp_head.char_index;
   assign rsp_char_valid  = rsp_head.char_valid;
   assign rsp_end_of_text = rsp_head.end_of_text;

endmodule : ctc_greedy_decoder_unit

`default_nettype wire
